FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; pulled in with an include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLIES(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bcg_pkg.sv
// shared constants and types of the block-cyclic index mapper
// no dependencies
package bcg_pkg;

  localparam int GRID_W    = 9;    // grid size and signed source coordinate
  localparam int COORD_W   = 8;    // process coordinate and relative coordinate
  localparam int MAX_GRID  = 256;  // grid sizes above this saturate
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_BS   = 3'd0,
    REG_COL_BS   = 3'd1,
    REG_ROW_FB   = 3'd2,
    REG_COL_FB   = 3'd3,
    REG_ROW_SRC  = 3'd4,
    REG_COL_SRC  = 3'd5,
    REG_ROW_GRID = 3'd6,
    REG_COL_GRID = 3'd7
  } cfg_reg_t;

  // grid settings of one dimension
  typedef struct packed {
    logic [GRID_W-1:0] src;  // signed, negative means not distributed
    logic [GRID_W-1:0] dim;
  } grid_cfg_t;

endpackage

FILE: hw/rtl/bcg_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; divisor must be non-zero and held while beats are in flight
module bcg_div #(
  parameter int DW = 31,
  parameter int VW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] den,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  logic [VW-1:0] rem_r  [DW];
  logic [DW-1:0] word_r [DW];

  genvar k;
  for (k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] r_in;
    logic [DW-1:0] w_in;
    logic [VW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign w_in = dividend;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign w_in = word_r[k-1];
    end

    assign trial = {r_in, w_in[DW-1]};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? VW'(trial - {1'b0, den}) : trial[VW-1:0];
        word_r[k] <= {w_in[DW-2:0], ge};
      end
    end
  end

  assign quot = word_r[DW-1];
  assign rem  = rem_r[DW-1];

endmodule

FILE: hw/rtl/bcg_delay.sv
// enabled delay line that keeps side data level with a divider
// no dependencies
module bcg_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  if (DEPTH == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [W-1:0] tap [DEPTH];

    always_ff @(posedge clk) begin
      if (en) begin
        tap[0] <= d;
        for (int k = 1; k < DEPTH; k++) tap[k] <= tap[k-1];
      end
    end

    assign q = tap[DEPTH-1];
  end

endmodule

FILE: hw/rtl/bcg_lane.sv
// one dimension of the index map: owner, relative coordinate, local start,
// local count and clipped first block; depends on bcg_pkg, bcg_div, bcg_delay
module bcg_lane
  import bcg_pkg::*;
#(
  parameter int IW = 31
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [IW-1:0]             blk_size,
  input  logic [IW-1:0]             first_blk,
  input  grid_cfg_t                 grid,
  input  logic [IW-1:0]             count_in,
  input  logic [IW-1:0]             start_in,
  input  logic [COORD_W-1:0]        coord,
  output logic [IW-1:0]             first_out,
  output logic [IW-1:0]             count_out,
  output logic [IW-1:0]             start_out,
  output logic signed [GRID_W-1:0]  owner_out,
  output logic [COORD_W-1:0]        rel_out
);

  typedef struct packed {
    logic [IW-1:0] m;
    logic [IW-1:0] i;
    logic          lead;
  } pay0_t;

  typedef struct packed {
    logic [IW-1:0]     first;
    logic [IW-1:0]     m;
    logic [IW-1:0]     i;
    logic              lead;
    logic [IW-1:0]     r1;
    logic [GRID_W-1:0] d;
    logic [GRID_W-1:0] s;
    logic [GRID_W-1:0] me;
    logic              gt;
  } pay2_t;

  typedef struct packed {
    logic [IW-1:0]     first;
    logic [IW-1:0]     m;
    logic [IW-1:0]     i;
    logic              lead;
    logic [IW-1:0]     r1;
    logic [GRID_W-1:0] d;
    logic [GRID_W-1:0] me;
    logic              gt;
    logic [GRID_W-1:0] own;
    logic [IW-1:0]     blk1;
    logic [IW-1:0]     r3;
  } pay4_t;

  // static settings, zero sizes read as one, grid sizes above MAX_GRID saturate
  logic [IW-1:0]     bs, fb;
  logic [GRID_W-1:0] p;
  logic              src_neg, spread;

  assign bs      = (blk_size == '0) ? IW'(1) : blk_size;
  assign fb      = (first_blk == '0) ? IW'(1) : first_blk;
  assign p       = (grid.dim == '0) ? GRID_W'(1) :
                   (grid.dim > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid.dim;
  assign src_neg = grid.src[GRID_W-1];
  assign spread  = !src_neg && (p != GRID_W'(1));

  // entry: offset past the first block, source and own coordinate mod grid
  pay0_t             pay0, pay0d;
  logic [IW-1:0]     q1, r1;
  logic [GRID_W-1:0] s_raw, me_raw, s1, me1;

  assign pay0.m    = count_in;
  assign pay0.i    = start_in;
  assign pay0.lead = (start_in < fb);

  bcg_div #(.DW(IW), .VW(IW)) u_div_off (
    .clk, .en, .dividend(start_in - fb), .den(bs), .quot(q1), .rem(r1)
  );

  bcg_div #(.DW(COORD_W), .VW(GRID_W)) u_div_src (
    .clk, .en, .dividend(grid.src[COORD_W-1:0]), .den(p), .quot(), .rem(s_raw)
  );

  bcg_div #(.DW(COORD_W), .VW(GRID_W)) u_div_me (
    .clk, .en, .dividend(coord), .den(p), .quot(), .rem(me_raw)
  );

  bcg_delay #(.W(2*GRID_W), .DEPTH(IW-COORD_W)) u_dly_coord (
    .clk, .en, .d({s_raw, me_raw}), .q({s1, me1})
  );

  bcg_delay #(.W($bits(pay0_t)), .DEPTH(IW)) u_dly0 (
    .clk, .en, .d(pay0), .q(pay0d)
  );

  // first block of the submatrix, distance from the source
  logic [IW-1:0]     p1_first, p1_q1, p1_r1, p1_m, p1_i;
  logic              p1_lead;
  logic [GRID_W-1:0] p1_d, p1_s, p1_me;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_first <= pay0d.lead ? fb - pay0d.i : bs - r1;
      p1_q1    <= q1;
      p1_r1    <= r1;
      p1_m     <= pay0d.m;
      p1_i     <= pay0d.i;
      p1_lead  <= pay0d.lead;
      p1_d     <= (me1 >= s1) ? me1 - s1 : GRID_W'(me1 + p - s1);
      p1_s     <= s1;
      p1_me    <= me1;
    end
  end

  // rest of the count past the first block
  logic [IW-1:0] p2_q1, p2_rest;
  pay2_t         p2_pay, pay2d;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_q1        <= p1_q1;
      p2_rest      <= (p1_m > p1_first) ? p1_m - p1_first : '0;
      p2_pay.first <= p1_first;
      p2_pay.m     <= p1_m;
      p2_pay.i     <= p1_i;
      p2_pay.lead  <= p1_lead;
      p2_pay.r1    <= p1_r1;
      p2_pay.d     <= p1_d;
      p2_pay.s     <= p1_s;
      p2_pay.me    <= p1_me;
      p2_pay.gt    <= (p1_m > p1_first);
    end
  end

  logic [IW-1:0]     q2, q3, r3;
  logic [GRID_W-1:0] r2;

  bcg_div #(.DW(IW), .VW(GRID_W)) u_div_blk (
    .clk, .en, .dividend(p2_q1), .den(p), .quot(q2), .rem(r2)
  );

  bcg_div #(.DW(IW), .VW(IW)) u_div_rest (
    .clk, .en, .dividend(p2_rest), .den(bs), .quot(q3), .rem(r3)
  );

  bcg_delay #(.W($bits(pay2_t)), .DEPTH(IW)) u_dly2 (
    .clk, .en, .d(p2_pay), .q(pay2d)
  );

  // owner of the start, whole blocks before it on this process
  logic [GRID_W:0] own_sum;
  logic [IW-1:0]   p3_q3;
  pay4_t           p3_pay, pay4d;

  assign own_sum = {1'b0, pay2d.s} + {1'b0, r2} + (GRID_W+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_q3        <= q3;
      p3_pay.first <= pay2d.first;
      p3_pay.m     <= pay2d.m;
      p3_pay.i     <= pay2d.i;
      p3_pay.lead  <= pay2d.lead;
      p3_pay.r1    <= pay2d.r1;
      p3_pay.d     <= pay2d.d;
      p3_pay.me    <= pay2d.me;
      p3_pay.gt    <= pay2d.gt;
      p3_pay.r3    <= r3;
      p3_pay.blk1  <= q2 + IW'((pay2d.d != '0) && (r2 >= pay2d.d));
      if (pay2d.lead) begin
        p3_pay.own <= pay2d.s;
      end else if (own_sum >= {1'b0, p}) begin
        p3_pay.own <= GRID_W'(own_sum - {1'b0, p});
      end else begin
        p3_pay.own <= own_sum[GRID_W-1:0];
      end
    end
  end

  logic [IW-1:0]     q4;
  logic [GRID_W-1:0] r4;

  bcg_div #(.DW(IW), .VW(GRID_W)) u_div_cnt (
    .clk, .en, .dividend(p3_q3), .den(p), .quot(q4), .rem(r4)
  );

  bcg_delay #(.W($bits(pay4_t)), .DEPTH(IW)) u_dly4 (
    .clk, .en, .d(p3_pay), .q(pay4d)
  );

  // distance to the owner, start products
  logic [IW-1:0]     p5_mul, p5_st0, p5_q4, p5_first, p5_m, p5_i, p5_r3;
  logic [GRID_W-1:0] p5_e, p5_r4, p5_own;
  logic              p5_own_hit, p5_lead, p5_gt;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_e       <= (pay4d.me >= pay4d.own) ? pay4d.me - pay4d.own :
                                              GRID_W'(pay4d.me + p - pay4d.own);
      p5_mul     <= IW'(pay4d.blk1 * bs);
      p5_st0     <= ((pay4d.d == '0) ? fb : '0) +
                    ((pay4d.me == pay4d.own) ? pay4d.r1 : '0);
      p5_own_hit <= (pay4d.me == pay4d.own);
      p5_q4      <= q4;
      p5_r4      <= r4;
      p5_first   <= pay4d.first;
      p5_m       <= pay4d.m;
      p5_i       <= pay4d.i;
      p5_lead    <= pay4d.lead;
      p5_gt      <= pay4d.gt;
      p5_own     <= pay4d.own;
      p5_r3      <= pay4d.r3;
    end
  end

  // local start, whole blocks of the count, partial last block
  logic [GRID_W-1:0] r4_inc, nb_mod;
  logic [IW-1:0]     p6_start, p6_blk, p6_first, p6_m, p6_r3;
  logic [GRID_W-1:0] p6_e, p6_own;
  logic              p6_hit, p6_gt;

  assign r4_inc = p5_r4 + GRID_W'(1);
  assign nb_mod = (r4_inc == p) ? '0 : r4_inc;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!spread) begin
        p6_start <= p5_i;
      end else if (p5_lead) begin
        p6_start <= p5_own_hit ? p5_i : '0;
      end else begin
        p6_start <= p5_st0 + p5_mul;
      end
      p6_blk   <= p5_q4 + IW'((p5_e != '0) && (p5_r4 >= p5_e));
      p6_hit   <= (nb_mod == p5_e);
      p6_first <= p5_first;
      p6_m     <= p5_m;
      p6_r3    <= p5_r3;
      p6_e     <= p5_e;
      p6_own   <= p5_own;
      p6_gt    <= p5_gt;
    end
  end

  logic [IW-1:0]     p7_mul, p7_cnt0, p7_start, p7_first, p7_m;
  logic [GRID_W-1:0] p7_e, p7_own;
  logic              p7_gt;

  always_ff @(posedge clk) begin
    if (en) begin
      p7_mul   <= IW'(p6_blk * bs);
      p7_cnt0  <= ((p6_e == '0) ? p6_first : '0) + (p6_hit ? p6_r3 : '0);
      p7_start <= p6_start;
      p7_first <= p6_first;
      p7_m     <= p6_m;
      p7_e     <= p6_e;
      p7_own   <= p6_own;
      p7_gt    <= p6_gt;
    end
  end

  // lane result
  always_ff @(posedge clk) begin
    if (en) begin
      first_out <= p7_gt ? p7_first : p7_m;
      start_out <= p7_start;
      if (!spread) begin
        count_out <= p7_m;
      end else if (p7_gt) begin
        count_out <= p7_cnt0 + p7_mul;
      end else begin
        count_out <= (p7_e == '0) ? p7_m : '0;
      end
      if (src_neg) begin
        owner_out <= '1;
      end else if (!spread) begin
        owner_out <= '0;
      end else begin
        owner_out <= $signed(p7_own);
      end
      rel_out <= spread ? p7_e[COORD_W-1:0] : '0;
    end
  end

endmodule

FILE: hw/rtl/block_cyclic_global_to_local.sv
// top level of the block-cyclic global-to-local index mapper
// depends on bcg_pkg, bcg_lane (bcg_div, bcg_delay) and assert_macros.svh
//
//  channel  | direction | beat
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | one submatrix query (row and column extent)
//  m_axis   | out       | one mapping result for the row and column lanes
//  cfg      | in        | one register write, index and data
//
// takes one beat every cycle while the skid stage is empty; a result passes through
// the three restoring dividers chained inside each lane and then the output register
// the output register plus a skid stage keep input taking beats while a result waits
// reset clears the valid bits and loads the register defaults, no clearing pass
// input stalls only once the skid stage holds a beat, and while reset is high
`include "assert_macros.svh"

module block_cyclic_global_to_local
  import bcg_pkg::*;
#(
  parameter int INDEX_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sub_rows, sub_cols, start_row, start_col, my_row, my_col, zero pad
  input  logic [((4*INDEX_WIDTH + 2*COORD_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // first_rows_out, first_cols_out, local_rows, local_cols, local_row_start,
  // local_col_start, owner_row, owner_col, rel_row, rel_col, zero pad
  output logic [((6*INDEX_WIDTH + 2*GRID_W + 2*COORD_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((INDEX_WIDTH > GRID_W) ? INDEX_WIDTH : GRID_W) - 1:0] cfg_data
);

  localparam int IW    = INDEX_WIDTH;
  localparam int IN_W  = ((4*IW + 2*COORD_W + 7) / 8) * 8;
  localparam int OUT_W = ((6*IW + 2*GRID_W + 2*COORD_W + 7) / 8) * 8;
  localparam int CDW   = (IW > GRID_W) ? IW : GRID_W;
  // lane depth: three dividers of IW stages plus seven single stages
  localparam int LAT   = 3*IW + 7;

  // configuration registers, writable whenever out of reset
  logic [IW-1:0] row_bs, col_bs, row_fb, col_fb;
  grid_cfg_t     row_grid, col_grid;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bs   <= IW'(1);
      col_bs   <= IW'(1);
      row_fb   <= IW'(1);
      col_fb   <= IW'(1);
      row_grid <= '{src: '0, dim: GRID_W'(1)};
      col_grid <= '{src: '0, dim: GRID_W'(1)};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_BS:   row_bs       <= cfg_data[IW-1:0];
        REG_COL_BS:   col_bs       <= cfg_data[IW-1:0];
        REG_ROW_FB:   row_fb       <= cfg_data[IW-1:0];
        REG_COL_FB:   col_fb       <= cfg_data[IW-1:0];
        REG_ROW_SRC:  row_grid.src <= cfg_data[GRID_W-1:0];
        REG_COL_SRC:  col_grid.src <= cfg_data[GRID_W-1:0];
        REG_ROW_GRID: row_grid.dim <= cfg_data[GRID_W-1:0];
        REG_COL_GRID: col_grid.dim <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together; it stops only when the skid is full
  logic           adv;
  logic [LAT-1:0] pipe_v;
  logic           out_valid, skid_valid;
  logic [OUT_W-1:0] out_data, skid_data, pipe_data;

  assign adv           = !skid_valid;
  assign s_axis_tready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (adv) begin
      pipe_v <= {pipe_v[LAT-2:0], s_axis_tvalid};
    end
  end

  // two lanes, rows and columns
  logic [IW-1:0]             row_first, row_count, row_start;
  logic [IW-1:0]             col_first, col_count, col_start;
  logic signed [GRID_W-1:0]  row_owner, col_owner;
  logic [COORD_W-1:0]        row_rel, col_rel;

  bcg_lane #(.IW(IW)) u_row_lane (
    .clk, .en(adv),
    .blk_size(row_bs), .first_blk(row_fb), .grid(row_grid),
    .count_in(s_axis_tdata[0*IW +: IW]),
    .start_in(s_axis_tdata[2*IW +: IW]),
    .coord(s_axis_tdata[4*IW +: COORD_W]),
    .first_out(row_first), .count_out(row_count), .start_out(row_start),
    .owner_out(row_owner), .rel_out(row_rel)
  );

  bcg_lane #(.IW(IW)) u_col_lane (
    .clk, .en(adv),
    .blk_size(col_bs), .first_blk(col_fb), .grid(col_grid),
    .count_in(s_axis_tdata[1*IW +: IW]),
    .start_in(s_axis_tdata[3*IW +: IW]),
    .coord(s_axis_tdata[4*IW+COORD_W +: COORD_W]),
    .first_out(col_first), .count_out(col_count), .start_out(col_start),
    .owner_out(col_owner), .rel_out(col_rel)
  );

  // merge both lanes into one result beat
  assign pipe_data = OUT_W'({col_rel, row_rel, col_owner, row_owner,
                             col_start, row_start, col_count, row_count,
                             col_first, row_first});

  // output register with skid stage
  logic push, pop;

  assign push = pipe_v[LAT-1] && adv;
  assign pop  = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= pipe_data;
      end else begin
        out_data <= pipe_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // checks
  `ASSERT_IMPLIES(a_skid_has_head, clk, rst, skid_valid, out_valid, "skid full with empty head")
  `ASSERT_NEXT(a_skid_holds_pipe, clk, rst, skid_valid, $stable(pipe_v), "pipeline moved on full skid")
  `ASSERT_NEXT(a_exit_lands, clk, rst, pipe_v[LAT-1] && !skid_valid, m_axis_tvalid, "result beat lost")

endmodule
